// ===== hdl/mhpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Operation and status codes, stream field widths and the control word that
// the queue controller sends along the row of cells.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// Stream field widths
	localparam int unsigned IN_VALUE_W  = 32;
	localparam int unsigned IN_DATA_W   = 32;
	localparam int unsigned OUT_VALUE_W = 32;
	localparam int unsigned OCC_W       = 7;
	localparam int unsigned OUT_DATA_W  = 40;
	localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_VALUE_W - OCC_W;

	// Operation carried in the input tuser
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} mhpq_op_t;

	// Status carried in the output tuser
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} mhpq_status_t;

	// Command broadcast to every cell in the row
	typedef struct packed {
		logic ins;
		logic rem;
	} mhpq_ctl_t;

endpackage : mhpq_pkg
`default_nettype wire

// ===== hdl/mhpq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue cell
// One slot of the sorted row. The row is kept in descending order, so an
// insert opens a gap at the first slot smaller than the new value and a
// removal shifts every entry one slot towards the head.
// ----------------------------------------------------------------------------
module mhpq_cell #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  mhpq_pkg::mhpq_ctl_t          ctl,
	input  wire logic [VALUE_WIDTH-1:0]  ins_value,
	input  wire logic [VALUE_WIDTH-1:0]  prev_value,
	input  wire logic                    prev_valid,
	input  wire logic                    prev_ge,
	input  wire logic [VALUE_WIDTH-1:0]  next_value,
	input  wire logic                    next_valid,
	output logic      [VALUE_WIDTH-1:0]  value,
	output logic                         valid,
	output logic                         ge
);
	import mhpq_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] value_d;
	logic                   valid_d;

	// This slot keeps its entry on an insert when it is at least the new value.
	assign ge = valid_q && ($signed(value_q) >= $signed(ins_value));

	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		if (ctl.ins) begin
			if (!ge) begin
				value_d = prev_ge ? ins_value : prev_value;
			end
			valid_d = valid_q | prev_valid;
		end else if (ctl.rem) begin
			value_d = next_value;
			valid_d = next_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule : mhpq_cell
`default_nettype wire

// ===== hdl/max_heap_priority_queue.sv =====
`default_nettype none
// A result appears in the output register in the cycle after its transaction is accepted.
// Throughput: one item per cycle while the output is not stalled; every cell of the row updates in
// the same cycle, so an insert or a removal does not slow down with the occupancy.
// The input stalls only while the output register holds a result that has not been taken.
// Reset (arst_n low) empties the queue at once and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Priority queue of signed words that returns the largest entry on removal.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int unsigned CAPACITY    = 64,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	// Input stream
	input  wire                                        s_tvalid,
	output logic                                       s_tready,
	input  wire logic [mhpq_pkg::IN_DATA_W-1:0]        s_tdata,  // [31:0] new_value
	input  wire logic [0:0]                            s_tuser,  // [0] operation
	// Output stream
	output logic                                       m_tvalid,
	input  wire                                        m_tready,
	output logic      [mhpq_pkg::OUT_DATA_W-1:0]       m_tdata,  // [31:0] removed_value,
	                                                             // [38:32] occupancy, [39] zero
	output logic      [1:0]                            m_tuser   // [1:0] status
);
	import mhpq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// The entries live in a row of cells sorted in descending order, so the
	// head cell always holds the maximum. Equal values cannot be told apart,
	// which means the row returns exactly what a binary heap would return.

	logic [CNT_W-1:0]        count_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	mhpq_status_t            m_tuser_q;

	logic                    accept;
	mhpq_op_t                op;
	logic                    full;
	logic                    empty;
	mhpq_ctl_t               ctl;
	logic [VALUE_WIDTH-1:0]  ins_value;
	logic [OUT_VALUE_W-1:0]  head_ext;

	logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
	logic                    cell_valid [CAPACITY];
	logic                    cell_ge    [CAPACITY];

	// A new transaction may enter whenever the output register is free or is
	// being emptied in the same cycle.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = mhpq_op_t'(s_tuser[0]);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// An insert into a full queue and a removal from an empty one leave the
	// row untouched; only the status reports them.
	assign ctl.ins = accept && (op == OP_INSERT) && !full;
	assign ctl.rem = accept && (op == OP_REMOVE) && !empty;

	// The value is held at VALUE_WIDTH bits. A narrower store keeps the low
	// bits of the input word, a wider one zero-extends it. On the way out the
	// stored word is sign-extended or truncated back to the output width.
	generate
		if (VALUE_WIDTH <= IN_VALUE_W) begin : g_in_narrow
			assign ins_value = s_tdata[VALUE_WIDTH-1:0];
		end else begin : g_in_wide
			assign ins_value = {{(VALUE_WIDTH-IN_VALUE_W){1'b0}}, s_tdata[IN_VALUE_W-1:0]};
		end
		if (VALUE_WIDTH >= OUT_VALUE_W) begin : g_out_wide
			assign head_ext = cell_value[0][OUT_VALUE_W-1:0];
		end else begin : g_out_narrow
			assign head_ext = {{(OUT_VALUE_W-VALUE_WIDTH){cell_value[0][VALUE_WIDTH-1]}},
				cell_value[0]};
		end
	endgenerate

	// Row of cells. Each cell sees the slot before it (to take over its entry
	// when an insert pushes the tail down) and the slot after it (to pull the
	// next entry up on a removal). The head cell treats the slot before it as
	// an unbeatable valid entry; the tail cell sees an empty slot after it.
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [VALUE_WIDTH-1:0] prev_value;
			logic                   prev_valid;
			logic                   prev_ge;
			logic [VALUE_WIDTH-1:0] next_value;
			logic                   next_valid;

			if (i == 0) begin : g_head
				assign prev_value = ins_value;
				assign prev_valid = 1'b1;
				assign prev_ge    = 1'b1;
			end else begin : g_body
				assign prev_value = cell_value[i-1];
				assign prev_valid = cell_valid[i-1];
				assign prev_ge    = cell_ge[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign next_value = cell_value[i];
				assign next_valid = 1'b0;
			end else begin : g_inner
				assign next_value = cell_value[i+1];
				assign next_valid = cell_valid[i+1];
			end

			mhpq_cell #(
				.VALUE_WIDTH (VALUE_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.ins_value  (ins_value),
				.prev_value (prev_value),
				.prev_valid (prev_valid),
				.prev_ge    (prev_ge),
				.next_value (next_value),
				.next_valid (next_valid),
				.value      (cell_value[i]),
				.valid      (cell_valid[i]),
				.ge         (cell_ge[i])
			);
		end
	endgenerate

	// Entry count and output register. The result word is formed from the
	// head cell before the row shifts, and the occupancy from the count after
	// this transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (op == OP_INSERT) begin
				m_tuser_q <= full ? ST_FULL : ST_INSERTED;
				m_tdata_q <= {{OUT_PAD_W{1'b0}}, OCC_W'(full ? count_q : count_q + CNT_W'(1)),
					{OUT_VALUE_W{1'b0}}};
			end else if (empty) begin
				m_tuser_q <= ST_EMPTY;
				m_tdata_q <= {{OUT_PAD_W{1'b0}}, OCC_W'(count_q), {OUT_VALUE_W{1'b1}}};
			end else begin
				m_tuser_q <= ST_REMOVED;
				m_tdata_q <= {{OUT_PAD_W{1'b0}}, OCC_W'(count_q - CNT_W'(1)), head_ext};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule : max_heap_priority_queue
`default_nettype wire

// ===== hdl/mhpq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Port-level checks on the result stream of the priority queue.
// ----------------------------------------------------------------------------
module mhpq_port_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	input  wire                                   s_tready,
	input  wire                                   m_tvalid,
	input  wire                                   m_tready,
	input  wire logic [mhpq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire logic [1:0]                       m_tuser
);
	import mhpq_pkg::*;

	logic [OUT_VALUE_W-1:0] out_value;
	logic [OCC_W-1:0]       out_occ;

	assign out_value = m_tdata[OUT_VALUE_W-1:0];
	assign out_occ   = m_tdata[OUT_VALUE_W+OCC_W-1:OUT_VALUE_W];

	// A result that waits is held unchanged until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An empty removal reports all ones and an empty queue.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (out_value == '1) && (out_occ == '0))
		else $error("empty removal result malformed");

	// Inserts, taken or dropped, carry a zero value word.
	a_ins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == ST_INSERTED) || (m_tuser == ST_FULL)) |-> (out_value == '0))
		else $error("insert result carries a value");

	// A new result is produced only for an accepted transaction.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without a transaction");

endmodule : mhpq_port_checker

bind max_heap_priority_queue mhpq_port_checker u_mhpq_checker (.*);
`default_nettype wire

// ===== tb/mhpq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Watches both streams, keeps its own heap of the queued words and compares
// every result with the one predicted for the oldest outstanding transaction.
// ----------------------------------------------------------------------------
module mhpq_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	input  wire                                  s_tready,
	input  wire [mhpq_pkg::IN_DATA_W-1:0]        s_tdata,
	input  wire [0:0]                            s_tuser,
	input  wire                                  m_tvalid,
	input  wire                                  m_tready,
	input  wire [mhpq_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire [1:0]                            m_tuser,
	output int                                   failures,
	output int                                   pending
);
	import mhpq_pkg::*;

	localparam int unsigned HEAP_SLOTS = 64;

	typedef struct {
		logic [OUT_VALUE_W-1:0] removed;
		mhpq_status_t           status;
		logic [OCC_W-1:0]       occupancy;
	} queue_result_t;

	logic signed [IN_VALUE_W-1:0] heap_words [HEAP_SLOTS];
	int unsigned                  heap_size;
	queue_result_t                awaited_results [$];

	task automatic swap_words(input int unsigned p, input int unsigned q);
		logic signed [IN_VALUE_W-1:0] t;
		t = heap_words[p];
		heap_words[p] = heap_words[q];
		heap_words[q] = t;
	endtask

	// Applies one operation to the shadow heap and returns the result it causes.
	task automatic heap_predict(input mhpq_op_t op, input logic signed [IN_VALUE_W-1:0] word,
			output queue_result_t res);
		int unsigned i;
		int unsigned parent;
		int unsigned best;
		int unsigned left;
		int unsigned right;
		bit settled;
		res.removed = '0;
		if (op == OP_INSERT) begin
			if (heap_size >= HEAP_SLOTS) begin
				res.status = ST_FULL;
			end else begin
				heap_words[heap_size] = word;
				i = heap_size;
				heap_size++;
				settled = 0;
				// Sift up; an equal parent stays where it is.
				while (i > 0 && !settled) begin
					parent = (i - 1) / 2;
					if (heap_words[parent] < heap_words[i]) begin
						swap_words(parent, i);
						i = parent;
					end else begin
						settled = 1;
					end
				end
				res.status = ST_INSERTED;
			end
		end else begin
			if (heap_size == 0) begin
				res.removed = '1;
				res.status  = ST_EMPTY;
			end else begin
				res.removed = heap_words[0];
				heap_size--;
				heap_words[0] = heap_words[heap_size];
				i = 0;
				settled = 0;
				// Sift down past the larger child; an equal child is not swapped.
				while (!settled) begin
					best  = i;
					left  = 2 * i + 1;
					right = 2 * i + 2;
					if (left < heap_size && heap_words[best] < heap_words[left])
						best = left;
					if (right < heap_size && heap_words[best] < heap_words[right])
						best = right;
					if (best == i) begin
						settled = 1;
					end else begin
						swap_words(best, i);
						i = best;
					end
				end
				res.status = ST_REMOVED;
			end
		end
		res.occupancy = heap_size[OCC_W-1:0];
	endtask

	task automatic report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		failures++;
		if (failures <= 10)
			$display("Mismatch on %s: expected %0h, got %0h", field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		queue_result_t next_res;
		if (!arst_n) begin
			awaited_results.delete();
			heap_size = 0;
			failures  = 0;
			pending   = 0;
		end else begin
			// A result taken at this edge belongs to an earlier transaction, so it is
			// checked before the input accepted at the same edge is predicted.
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_field("unexpected result", 64'h0, {24'h0, m_tdata});
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata[OUT_VALUE_W-1:0] !== want.removed)
						report_field("removed_value", 64'(want.removed),
							64'(m_tdata[OUT_VALUE_W-1:0]));
					if (m_tdata[OUT_VALUE_W +: OCC_W] !== want.occupancy)
						report_field("occupancy", 64'(want.occupancy),
							64'(m_tdata[OUT_VALUE_W +: OCC_W]));
					if (m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0)
						report_field("padding", 64'h0,
							64'(m_tdata[OUT_DATA_W-1 -: OUT_PAD_W]));
					if (m_tuser !== want.status)
						report_field("status", 64'(want.status), 64'(m_tuser));
				end
			end
			if (s_tvalid && s_tready) begin
				heap_predict(mhpq_op_t'(s_tuser[0]), s_tdata[IN_VALUE_W-1:0], next_res);
				awaited_results.push_back(next_res);
			end
			pending = awaited_results.size();
		end
	end

endmodule : mhpq_checker
`default_nettype wire

// ===== tb/tb_max_heap_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives inserts and removals with random gaps, a long output hold-off and a
// full drain, while the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
	import mhpq_pkg::*;

	localparam int RANDOM_ITEMS  = 1030;
	localparam int PHASE_LEN     = 150;
	// The sender runs without gaps for these random transactions.
	localparam int STEADY_FIRST  = 600;
	localparam int STEADY_LAST   = 780;
	// Before this random transaction the sender waits until the queue has answered everything.
	localparam int DRAIN_AT      = 520;
	// The receiver refuses results for a long stretch starting at this cycle.
	localparam int HOLD_START    = 900;
	localparam int HOLD_CYCLES   = 300;
	localparam int RX_STEADY_LO  = 1700;
	localparam int RX_STEADY_HI  = 2100;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;   // [31:0] new_value
	logic [0:0]              s_tuser;   // [0] operation
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;   // [31:0] removed_value, [38:32] occupancy, [39] zero
	logic [1:0]              m_tuser;   // [1:0] status
	int                      failures;
	int                      pending;

	max_heap_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mhpq_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Offers one transaction from a falling edge and returns at the falling edge
	// after it has been accepted. Idle cycles are inserted first unless the
	// sender is in its gap-free stretch.
	task automatic offer_item(input mhpq_op_t op, input logic [IN_VALUE_W-1:0] word,
			input bit no_gaps);
		while (!no_gaps && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Words are biased toward the extremes and a narrow band around zero so that
	// equal values meet often; the rest are full-width random.
	function automatic logic [IN_VALUE_W-1:0] pick_word();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'($signed($urandom_range(6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random back-pressure, one long refusal to force the queue to
	// stall its input, and a stretch in which every result is taken at once.
	initial begin
		int cycle;
		m_tready = 1'b0;
		cycle = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
				m_tready <= 1'b0;
			else if (cycle >= RX_STEADY_LO && cycle < RX_STEADY_HI)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 35);
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int insert_bias;
		bit quiet;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_INSERT;
		arst_n   = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: removal from an empty queue, the extreme words, equal
		// values on both sift directions, and a drain back to empty.
		offer_item(OP_REMOVE, 32'hFFFF_FFFF, 0);
		offer_item(OP_INSERT, 32'h7FFF_FFFF, 0);
		offer_item(OP_INSERT, 32'h8000_0000, 0);
		offer_item(OP_INSERT, 32'h0000_0000, 0);
		offer_item(OP_INSERT, 32'hFFFF_FFFF, 0);
		offer_item(OP_INSERT, 32'h8000_0000, 0);
		offer_item(OP_INSERT, 32'h0000_0005, 0);
		offer_item(OP_INSERT, 32'h0000_0005, 0);
		offer_item(OP_INSERT, 32'h7FFF_FFFF, 0);
		offer_item(OP_INSERT, 32'hAAAA_AAAA, 0);
		offer_item(OP_INSERT, 32'h5555_5555, 0);
		repeat (11)
			offer_item(OP_REMOVE, $urandom, 0);
		offer_item(OP_REMOVE, 32'h0000_0000, 0);

		// Random part in phases that lean toward inserts or removals, so the
		// queue is filled past capacity and emptied again several times.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ((n / PHASE_LEN) % 5)
				0:       insert_bias = 85;
				1:       insert_bias = 15;
				2:       insert_bias = 50;
				3:       insert_bias = 92;
				default: insert_bias = 8;
			endcase
			if (n == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			quiet = (n >= STEADY_FIRST && n < STEADY_LAST);
			if ($urandom_range(99) < insert_bias)
				offer_item(OP_INSERT, pick_word(), quiet);
			else
				offer_item(OP_REMOVE, $urandom, quiet);
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (5) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule : tb_max_heap_priority_queue
`default_nettype wire
